// ===== design/dfa_longest_match_scanner_unit_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the DFA scanner modules.
// ============================================================================
`ifndef DFA_LONGEST_MATCH_SCANNER_UNIT_MACROS_SVH
`define DFA_LONGEST_MATCH_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication.
`define DLMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlms implication check failed");

// Next-cycle implication.
`define DLMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlms next-cycle check failed");

// Condition that must never hold.
`define DLMS_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dlms forbidden condition seen");

`endif

// ===== design/dlms_pkg.sv =====
// ============================================================================
// dlms_pkg
// Types and constants shared by the DFA longest-match scanner modules.
// ============================================================================
package dlms_pkg;

    localparam int STATE_W  = 8;
    localparam int BYTE_W   = 8;
    localparam int TOKEN_W  = 8;
    localparam int LEN_W    = 16;
    localparam int CMD_W    = 2;
    localparam int TRANS_AW = STATE_W + BYTE_W;

    localparam logic [LEN_W-1:0]   LEN_MAX    = {LEN_W{1'b1}};
    localparam logic [STATE_W-1:0] START_STATE = STATE_W'(1);
    localparam logic [STATE_W-1:0] DEAD_STATE  = '0;
    localparam logic [TOKEN_W-1:0] NO_TOKEN    = '0;

    // Command codes on the input port
    localparam logic [CMD_W-1:0] CMD_STEP     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_TRANS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WR_ACC   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART  = 2'd3;

    typedef enum logic [1:0] {
        OP_STEP,
        OP_WR_TRANS,
        OP_WR_ACC,
        OP_RESTART
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [BYTE_W-1:0]  byte_value;
        logic [STATE_W-1:0] state_index;
        logic [STATE_W-1:0] next_state;
        logic [TOKEN_W-1:0] token_id;
    } t_item;

    typedef struct packed {
        logic hopeful;
        logic [TOKEN_W-1:0] match_id;
        logic [LEN_W-1:0]   match_length;
        logic [STATE_W-1:0] current_state;
    } t_result;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RD_TRANS,
        BK_RD_ACC
    } t_back_state;

endpackage

// ===== design/dlms_front.sv =====
// ============================================================================
// dlms_front
// Input stage: takes a transfer, decodes the command, holds it for the queue.
// ============================================================================
module dlms_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dlms_pkg::CMD_W-1:0]    i_command,
    input  logic [dlms_pkg::BYTE_W-1:0]   i_byte_value,
    input  logic [dlms_pkg::STATE_W-1:0]  i_state_index,
    input  logic [dlms_pkg::STATE_W-1:0]  i_next_state,
    input  logic [dlms_pkg::TOKEN_W-1:0]  i_token_id,
    output logic                          o_push,
    output dlms_pkg::t_item               o_item,
    input  logic                          i_q_ready
);

    logic            r_valid;
    dlms_pkg::t_item r_item;
    dlms_pkg::t_item n_item;
    logic            take;

    assign o_in_ready = !r_valid || i_q_ready;
    assign take       = i_in_valid && o_in_ready;
    assign o_push     = r_valid && i_q_ready;
    assign o_item     = r_item;

    always_comb begin
        n_item.byte_value  = i_byte_value;
        n_item.state_index = i_state_index;
        n_item.next_state  = i_next_state;
        n_item.token_id    = i_token_id;
        case (i_command)
            dlms_pkg::CMD_STEP:     n_item.op = dlms_pkg::OP_STEP;
            dlms_pkg::CMD_WR_TRANS: n_item.op = dlms_pkg::OP_WR_TRANS;
            dlms_pkg::CMD_WR_ACC:   n_item.op = dlms_pkg::OP_WR_ACC;
            default:                n_item.op = dlms_pkg::OP_RESTART;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== design/dlms_queue.sv =====
// ============================================================================
// dlms_queue
// Two-entry queue between the decode stage and the table engine.
// ============================================================================
`include "dfa_longest_match_scanner_unit_macros.svh"

module dlms_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dlms_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output dlms_pkg::t_item o_item,
    input  logic            i_pop
);

    dlms_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic [1:0]      n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `DLMS_ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && !o_ready)
    `DLMS_ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && !o_valid)
    `DLMS_ASSERT_IMPL(a_ptrs_track, i_clk, i_rst_n, r_count == 2'd1,
                      r_wr_ptr != r_rd_ptr)

endmodule

// ===== design/dlms_back.sv =====
// ============================================================================
// dlms_back
// Table engine: transition and accept memories, scan state, result register.
// ============================================================================
`include "dfa_longest_match_scanner_unit_macros.svh"

module dlms_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  dlms_pkg::t_item               i_item,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dlms_pkg::t_result             o_result
);

    // Tables: no reset; the user must read them only after written, the block does not enforce it
    logic [dlms_pkg::STATE_W-1:0] r_trans_mem [2**dlms_pkg::TRANS_AW];
    logic [dlms_pkg::TOKEN_W-1:0] r_acc_mem   [2**dlms_pkg::STATE_W];
    logic [dlms_pkg::STATE_W-1:0] r_trans_rd;
    logic [dlms_pkg::TOKEN_W-1:0] r_acc_rd;

    dlms_pkg::t_back_state r_fsm;
    dlms_pkg::t_back_state n_fsm;

    logic [dlms_pkg::STATE_W-1:0] r_scan_state, n_scan_state;
    logic [dlms_pkg::LEN_W-1:0]   r_scan_len,   n_scan_len;
    logic [dlms_pkg::TOKEN_W-1:0] r_best_tok,   n_best_tok;
    logic [dlms_pkg::LEN_W-1:0]   r_best_len,   n_best_len;

    logic               r_out_valid;
    dlms_pkg::t_result  r_result;

    logic out_free;
    logic start;
    logic trans_we, trans_re, acc_we, acc_re;
    logic restart, step_upd, out_load;
    logic [dlms_pkg::LEN_W-1:0] len_inc;

    assign out_free = !r_out_valid || i_out_ready;
    assign start    = i_q_valid && out_free;

    // Next state
    always_comb begin
        n_fsm = r_fsm;
        case (r_fsm)
            dlms_pkg::BK_IDLE: begin
                if (start && i_item.op == dlms_pkg::OP_STEP) begin
                    n_fsm = dlms_pkg::BK_RD_TRANS;
                end
            end
            dlms_pkg::BK_RD_TRANS: n_fsm = dlms_pkg::BK_RD_ACC;
            dlms_pkg::BK_RD_ACC:   n_fsm = dlms_pkg::BK_IDLE;
            default:               n_fsm = dlms_pkg::BK_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_pop    = 1'b0;
        trans_we = 1'b0;
        trans_re = 1'b0;
        acc_we   = 1'b0;
        acc_re   = 1'b0;
        restart  = 1'b0;
        step_upd = 1'b0;
        out_load = 1'b0;
        case (r_fsm)
            dlms_pkg::BK_IDLE: begin
                if (start) begin
                    o_pop = 1'b1;
                    case (i_item.op)
                        dlms_pkg::OP_STEP:     trans_re = 1'b1;
                        dlms_pkg::OP_WR_TRANS: begin
                            trans_we = 1'b1;
                            out_load = 1'b1;
                        end
                        dlms_pkg::OP_WR_ACC: begin
                            acc_we   = 1'b1;
                            out_load = 1'b1;
                        end
                        default: begin
                            restart  = 1'b1;
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            dlms_pkg::BK_RD_TRANS: acc_re = 1'b1;
            dlms_pkg::BK_RD_ACC: begin
                step_upd = 1'b1;
                out_load = 1'b1;
            end
            default: ;
        endcase
    end

    // Transition memory: address is {state row, byte column}
    always_ff @(posedge i_clk) begin
        if (trans_we) begin
            r_trans_mem[{i_item.state_index, i_item.byte_value}] <= i_item.next_state;
        end
        if (trans_re) begin
            r_trans_rd <= r_trans_mem[{r_scan_state, i_item.byte_value}];
        end
    end

    // Accept memory, read at the state just fetched
    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            r_acc_mem[i_item.state_index] <= i_item.token_id;
        end
        if (acc_re) begin
            r_acc_rd <= r_acc_mem[r_trans_rd];
        end
    end

    assign len_inc = (r_scan_len == dlms_pkg::LEN_MAX) ? r_scan_len
                                                       : r_scan_len + dlms_pkg::LEN_W'(1);

    always_comb begin
        n_scan_state = r_scan_state;
        n_scan_len   = r_scan_len;
        n_best_tok   = r_best_tok;
        n_best_len   = r_best_len;
        if (restart) begin
            n_scan_state = dlms_pkg::START_STATE;
            n_scan_len   = '0;
            n_best_tok   = dlms_pkg::NO_TOKEN;
            n_best_len   = dlms_pkg::LEN_W'(1);
        end else if (step_upd) begin
            n_scan_state = r_trans_rd;
            n_scan_len   = len_inc;
            if (r_acc_rd != dlms_pkg::NO_TOKEN) begin
                n_best_tok = r_acc_rd;
                n_best_len = len_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm        <= dlms_pkg::BK_IDLE;
            r_scan_state <= dlms_pkg::START_STATE;
            r_scan_len   <= '0;
            r_best_tok   <= dlms_pkg::NO_TOKEN;
            r_best_len   <= dlms_pkg::LEN_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            r_fsm        <= n_fsm;
            r_scan_state <= n_scan_state;
            r_scan_len   <= n_scan_len;
            r_best_tok   <= n_best_tok;
            r_best_len   <= n_best_len;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_result.hopeful       <= (n_scan_state != dlms_pkg::DEAD_STATE);
            r_result.match_id      <= n_best_tok;
            r_result.match_length  <= n_best_len;
            r_result.current_state <= n_scan_state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    `DLMS_ASSERT_IMPL(a_busy_out_empty, i_clk, i_rst_n,
                      r_fsm != dlms_pkg::BK_IDLE, !r_out_valid)
    `DLMS_ASSERT_IMPL(a_pop_idle, i_clk, i_rst_n, o_pop, r_fsm == dlms_pkg::BK_IDLE)
    `DLMS_ASSERT_NEXT(a_trans_then_acc, i_clk, i_rst_n,
                      r_fsm == dlms_pkg::BK_RD_TRANS, r_fsm == dlms_pkg::BK_RD_ACC)
    `DLMS_ASSERT_NEXT(a_step_grows, i_clk, i_rst_n,
                      step_upd && r_scan_len != dlms_pkg::LEN_MAX,
                      r_scan_len == $past(r_scan_len) + dlms_pkg::LEN_W'(1))

endmodule

// ===== design/dfa_longest_match_scanner_unit.sv =====
// Path: a table write or restart transfer goes through the decode register, the queue
//   and the result register; a step byte through decode stage, queue, transition read,
//   accept read and update. Flow: the engine takes no new transfer while a step byte does
//   its dependent transition then accept memory reads, or while the result waits untaken.
// Reset (i_rst_n low, synchronous): scan state 1, length 0, no match, match length 1,
//   queue and result register empty; transition and accept tables keep their contents.
// ============================================================================
// dfa_longest_match_scanner_unit
// Table-driven DFA scanner with longest-match tracking for a lexer front end.
// ============================================================================
module dfa_longest_match_scanner_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dlms_pkg::CMD_W-1:0]    i_command,
    input  logic [dlms_pkg::BYTE_W-1:0]   i_byte_value,
    input  logic [dlms_pkg::STATE_W-1:0]  i_state_index,
    input  logic [dlms_pkg::STATE_W-1:0]  i_next_state,
    input  logic [dlms_pkg::TOKEN_W-1:0]  i_token_id,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hopeful,
    output logic [dlms_pkg::TOKEN_W-1:0]  o_match_id,
    output logic [dlms_pkg::LEN_W-1:0]    o_match_length,
    output logic [dlms_pkg::STATE_W-1:0]  o_current_state
);

    // Front side: decode register feeding the queue
    logic            push;
    logic            q_ready;
    dlms_pkg::t_item front_item;

    // Back side: queue head and engine
    logic              q_valid;
    logic              pop;
    dlms_pkg::t_item   head_item;
    dlms_pkg::t_result result;

    dlms_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_byte_value  (i_byte_value),
        .i_state_index (i_state_index),
        .i_next_state  (i_next_state),
        .i_token_id    (i_token_id),
        .o_push        (push),
        .o_item        (front_item),
        .i_q_ready     (q_ready)
    );

    // Two entries let decode keep taking transfers while the engine
    // is busy with a step or stalled on the result channel.
    dlms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (head_item),
        .i_pop   (pop)
    );

    // Engine owns both tables and the scan registers; its result
    // register frees the engine as soon as the result is taken.
    dlms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_item      (head_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_hopeful       = result.hopeful;
    assign o_match_id      = result.match_id;
    assign o_match_length  = result.match_length;
    assign o_current_state = result.current_state;

endmodule
